FILE: hdl/ksc_pkg.sv
// constants shared by the glyph address pipeline: code segments, offsets and register indexes
package ksc_pkg;

  // lead byte segments
  localparam logic [7:0] LeadWideLo   = 8'h81;
  localparam logic [7:0] LeadWideHi   = 8'hC5;
  localparam logic [7:0] LeadTrunc    = 8'hC6;
  localparam logic [7:0] LeadC7       = 8'hC7;
  localparam logic [7:0] LeadC8       = 8'hC8;
  localparam logic [7:0] LeadCaLo     = 8'hCA;
  localparam logic [7:0] LeadCaHi     = 8'hFD;

  // trail byte ranges
  localparam logic [7:0] TrailUpLo    = 8'h41;
  localparam logic [7:0] TrailUpHi    = 8'h5A;
  localparam logic [7:0] TrailLowLo   = 8'h61;
  localparam logic [7:0] TrailLowHi   = 8'h7A;
  localparam logic [7:0] TrailExtLo   = 8'h81;
  localparam logic [7:0] TrailExtHi   = 8'hFE;
  localparam logic [7:0] TrailTruncHi = 8'h52;
  localparam logic [7:0] TrailNarLo   = 8'hA1;
  localparam logic [7:0] TrailNarHi   = 8'hFE;

  // glyph counts and segment bases
  localparam logic [14:0] SegWide     = 15'd178;
  localparam logic [14:0] SegNarrow   = 15'd94;
  localparam logic [14:0] BaseC6      = 15'd12282;
  localparam logic [14:0] BaseC7      = 15'd12394;
  localparam logic [14:0] BaseCa      = 15'd12582;
  localparam logic [14:0] OffLower    = 15'd26;
  localparam logic [14:0] OffExt      = 15'd52;
  localparam logic [14:0] OffTrunc    = 15'd18;
  localparam logic [14:0] MaxIndex    = 15'd17469;

  localparam logic [24:0] HeaderBytes = 25'd6;

  // configuration register indexes
  localparam logic [7:0] CfgFontBase  = 8'd0;
  localparam logic [7:0] CfgGlyphSize = 8'd1;

  localparam logic [23:0] FontBaseReset  = 24'd0;
  localparam logic [6:0]  GlyphSizeReset = 7'd16;
  localparam logic [10:0] GlyphBytesReset = 11'd32;

endpackage

FILE: hdl/ksc_glyph_address.sv
// glyph index and font file byte address of a double-byte korean character code
// Takes one char_code item per cycle while in_ready_o is high and returns one result per
// item. Stage one decodes the lead and trail bytes into a glyph index, stage two multiplies
// the index by the glyph byte size held in a register derived at configuration time, stage
// three adds the base offset and header and holds the result, zeroing it when no glyph is
// found. Each stage advances when it is empty or its successor takes its item, so a stall
// at the output backs up through the stages without loss. Configuration writes are
// always accepted and must only be issued while no item is in flight.
module ksc_glyph_address (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [14:0] glyph_index_o,
  output logic [24:0] byte_address_o,
  output logic [6:0]  glyph_height_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  // configuration
  logic [23:0] font_base_q;
  logic [6:0]  glyph_size_q;
  logic [10:0] glyph_bytes_q, glyph_bytes_d;
  logic [4:0]  size_cols;

  assign cfg_ready_o = 1'b1;
  assign size_cols   = 5'((8'(cfg_data_i[6:0]) + 8'd7) >> 3);
  assign glyph_bytes_d = 11'(size_cols) * 11'(cfg_data_i[6:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_base_q   <= ksc_pkg::FontBaseReset;
      glyph_size_q  <= ksc_pkg::GlyphSizeReset;
      glyph_bytes_q <= ksc_pkg::GlyphBytesReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ksc_pkg::CfgFontBase) begin
        font_base_q <= cfg_data_i;
      end else if (cfg_index_i == ksc_pkg::CfgGlyphSize) begin
        glyph_size_q  <= cfg_data_i[6:0];
        glyph_bytes_q <= glyph_bytes_d;
      end
    end
  end

  // stage handshake
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  assign adv3       = !v3_q || out_ready_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // stage one: code to glyph index
  logic        found1_d, found1_q;
  logic [14:0] idx1_d, idx1_q;

  always_comb begin
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [14:0] row;
    logic        nar_ok;
    logic [14:0] nar_pos;
    hi       = char_code_i[15:8];
    lo       = char_code_i[7:0];
    nar_ok   = lo inside {[ksc_pkg::TrailNarLo:ksc_pkg::TrailNarHi]};
    nar_pos  = 15'(lo - ksc_pkg::TrailNarLo);
    row      = '0;
    found1_d = 1'b0;
    idx1_d   = '0;
    if (hi inside {[ksc_pkg::LeadWideLo:ksc_pkg::LeadWideHi]}) begin
      row = 15'(15'(hi - ksc_pkg::LeadWideLo) * ksc_pkg::SegWide);
      if (lo inside {[ksc_pkg::TrailUpLo:ksc_pkg::TrailUpHi]}) begin
        found1_d = 1'b1;
        idx1_d   = row + 15'(lo - ksc_pkg::TrailUpLo);
      end else if (lo inside {[ksc_pkg::TrailLowLo:ksc_pkg::TrailLowHi]}) begin
        found1_d = 1'b1;
        idx1_d   = row + 15'(lo - ksc_pkg::TrailLowLo) + ksc_pkg::OffLower;
      end else if (lo inside {[ksc_pkg::TrailExtLo:ksc_pkg::TrailExtHi]}) begin
        found1_d = 1'b1;
        idx1_d   = row + 15'(lo - ksc_pkg::TrailExtLo) + ksc_pkg::OffExt;
      end
    end else if (hi == ksc_pkg::LeadTrunc) begin
      // truncated row: short upper-case run, then the narrow trail range
      if (lo inside {[ksc_pkg::TrailUpLo:ksc_pkg::TrailTruncHi]}) begin
        found1_d = 1'b1;
        idx1_d   = ksc_pkg::BaseC6 + 15'(lo - ksc_pkg::TrailUpLo);
      end else if (nar_ok) begin
        found1_d = 1'b1;
        idx1_d   = ksc_pkg::BaseC6 + nar_pos + ksc_pkg::OffTrunc;
      end
    end else if (hi == ksc_pkg::LeadC7 || hi == ksc_pkg::LeadC8) begin
      row = 15'(15'(hi - ksc_pkg::LeadC7) * ksc_pkg::SegNarrow);
      if (nar_ok) begin
        found1_d = 1'b1;
        idx1_d   = row + nar_pos + ksc_pkg::BaseC7;
      end
    end else if (hi inside {[ksc_pkg::LeadCaLo:ksc_pkg::LeadCaHi]}) begin
      row = 15'(15'(hi - ksc_pkg::LeadCaLo) * ksc_pkg::SegNarrow);
      if (nar_ok) begin
        found1_d = 1'b1;
        idx1_d   = row + nar_pos + ksc_pkg::BaseCa;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      found1_q <= found1_d;
      idx1_q   <= idx1_d;
    end
  end

  // stage two: index times glyph bytes
  logic        found2_q;
  logic [14:0] idx2_q;
  logic [24:0] prod2_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      found2_q <= found1_q;
      idx2_q   <= idx1_q;
      prod2_q  <= 25'(idx1_q) * 25'(glyph_bytes_q);
    end
  end

  // stage three: add base and header, zero the fields when not found
  logic        found3_q;
  logic [14:0] idx3_q;
  logic [24:0] addr3_q;
  logic [6:0]  height3_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      found3_q  <= found2_q;
      idx3_q    <= found2_q ? idx2_q : '0;
      addr3_q   <= found2_q ? 25'(25'(font_base_q) + ksc_pkg::HeaderBytes + prod2_q) : '0;
      height3_q <= found2_q ? glyph_size_q : '0;
    end
  end

  assign out_valid_o    = v3_q;
  assign found_o        = found3_q;
  assign glyph_index_o  = idx3_q;
  assign byte_address_o = addr3_q;
  assign glyph_height_o = height3_q;

  // checks
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |->
      glyph_index_o == '0 && byte_address_o == '0 && glyph_height_o == '0)
    else $error("not-found item carries nonzero fields");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> glyph_index_o <= ksc_pkg::MaxIndex)
    else $error("glyph index beyond last glyph");

  a_backpressure_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v1_q && v2_q && v3_q && !out_ready_i)
    else $error("input stalled while pipeline has room");

  a_stage2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !adv2 |=> v2_q && $stable(prod2_q) && $stable(idx2_q))
    else $error("stalled stage two item changed");

endmodule

FILE: sim/ksc_glyph_checker.sv
// checker for the glyph address block: predicts each result and compares it on the output channel
module ksc_glyph_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] char_code_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        found_i,
  input  logic [14:0] glyph_index_i,
  input  logic [24:0] byte_address_i,
  input  logic [6:0]  glyph_height_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output int          pending_o,
  output int          fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        found;
    logic [14:0] index;
    logic [24:0] address;
    logic [6:0]  height;
  } glyph_result_t;

  logic [23:0]   font_base_q;
  logic [6:0]    glyph_size_q;
  glyph_result_t expected_glyphs[$];
  int            mismatches = 0;

  function automatic glyph_result_t predict_glyph(logic [15:0] code);
    int unsigned   lead;
    int unsigned   trail;
    int unsigned   idx;
    int unsigned   glyph_bytes;
    longint unsigned addr;
    logic          hit;
    glyph_result_t res;
    lead  = code[15:8];
    trail = code[7:0];
    idx   = 0;
    hit   = 1'b0;
    if (lead >= ksc_pkg::LeadWideLo && lead <= ksc_pkg::LeadWideHi) begin
      idx = (lead - ksc_pkg::LeadWideLo) * ksc_pkg::SegWide;
      if (trail >= ksc_pkg::TrailUpLo && trail <= ksc_pkg::TrailUpHi) begin
        idx += trail - ksc_pkg::TrailUpLo;
        hit = 1'b1;
      end else if (trail >= ksc_pkg::TrailLowLo && trail <= ksc_pkg::TrailLowHi) begin
        idx += trail - ksc_pkg::TrailLowLo + ksc_pkg::OffLower;
        hit = 1'b1;
      end else if (trail >= ksc_pkg::TrailExtLo && trail <= ksc_pkg::TrailExtHi) begin
        idx += trail - ksc_pkg::TrailExtLo + ksc_pkg::OffExt;
        hit = 1'b1;
      end
    end else if (lead == ksc_pkg::LeadTrunc) begin
      // truncated row: a short upper-case run, then the 94-glyph run
      if (trail >= ksc_pkg::TrailUpLo && trail <= ksc_pkg::TrailTruncHi) begin
        idx = ksc_pkg::BaseC6 + trail - ksc_pkg::TrailUpLo;
        hit = 1'b1;
      end else if (trail >= ksc_pkg::TrailNarLo && trail <= ksc_pkg::TrailNarHi) begin
        idx = ksc_pkg::BaseC6 + ksc_pkg::OffTrunc + trail - ksc_pkg::TrailNarLo;
        hit = 1'b1;
      end
    end else if (lead == ksc_pkg::LeadC7 || lead == ksc_pkg::LeadC8) begin
      if (trail >= ksc_pkg::TrailNarLo && trail <= ksc_pkg::TrailNarHi) begin
        idx = ksc_pkg::BaseC7 + (lead - ksc_pkg::LeadC7) * ksc_pkg::SegNarrow
            + trail - ksc_pkg::TrailNarLo;
        hit = 1'b1;
      end
    end else if (lead >= ksc_pkg::LeadCaLo && lead <= ksc_pkg::LeadCaHi) begin
      if (trail >= ksc_pkg::TrailNarLo && trail <= ksc_pkg::TrailNarHi) begin
        idx = ksc_pkg::BaseCa + (lead - ksc_pkg::LeadCaLo) * ksc_pkg::SegNarrow
            + trail - ksc_pkg::TrailNarLo;
        hit = 1'b1;
      end
    end
    res = '0;
    if (hit) begin
      glyph_bytes = ((int'(glyph_size_q) + 7) / 8) * int'(glyph_size_q);
      addr = longint'(font_base_q) + longint'(ksc_pkg::HeaderBytes)
           + longint'(idx) * longint'(glyph_bytes);
      res.found   = 1'b1;
      res.index   = idx[14:0];
      res.address = addr[24:0];
      res.height  = glyph_size_q;
    end
    return res;
  endfunction

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    glyph_result_t want;
    if (!rst_ni) begin
      font_base_q  <= ksc_pkg::FontBaseReset;
      glyph_size_q <= ksc_pkg::GlyphSizeReset;
      expected_glyphs.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == ksc_pkg::CfgFontBase) font_base_q <= cfg_data_i;
        else if (cfg_index_i == ksc_pkg::CfgGlyphSize) glyph_size_q <= cfg_data_i[6:0];
      end
      // results always belong to older items, so compare before queueing the new one
      if (out_valid_i && out_ready_i) begin
        if (expected_glyphs.size() == 0) begin
          $display("%0t ns: unexpected result, found %0d index %0d address %0d height %0d",
                   $time, found_i, glyph_index_i, byte_address_i, glyph_height_i);
          mismatches++;
        end else begin
          want = expected_glyphs.pop_front();
          check_field("found", want.found, found_i);
          check_field("glyph_index", want.index, glyph_index_i);
          check_field("byte_address", want.address, byte_address_i);
          check_field("glyph_height", want.height, glyph_height_i);
        end
      end
      if (in_valid_i && in_ready_i) expected_glyphs.push_back(predict_glyph(char_code_i));
      pending_o    <= expected_glyphs.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: sim/ksc_glyph_address_tb.sv
// testbench top for the glyph address block: clock, reset, code stimulus, config phases, verdict
module ksc_glyph_address_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PhaseCount    = 9;
  localparam int          PhaseItems    = 200;
  localparam int          HoldCycles    = 300;
  localparam int          DrainCycles   = 10;
  localparam int          WatchdogLimit = 4000;
  localparam int          MaxGlyphSize  = 64;
  localparam logic [7:0]  CfgSpareLo    = ksc_pkg::CfgGlyphSize + 8'd1;
  localparam logic [23:0] BaseMax       = 24'hFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] char_code = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [14:0] glyph_index;
  logic [24:0] byte_address;
  logic [6:0]  glyph_height;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  int          pending;
  int          fail_count;

  int          send_gap_pct;
  int          recv_stall_pct;
  bit          rx_hold_req = 1'b0;
  int          quiet_cycles = 0;

  always #4ns clk = ~clk;

  ksc_glyph_address u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .char_code_i    (char_code),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .found_o        (found),
    .glyph_index_o  (glyph_index),
    .byte_address_o (byte_address),
    .glyph_height_o (glyph_height),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  ksc_glyph_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .char_code_i    (char_code),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .found_i        (found),
    .glyph_index_i  (glyph_index),
    .byte_address_i (byte_address),
    .glyph_height_i (glyph_height),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  // mostly legal codes with random content, the rest legal leads with any trail or pure noise
  function automatic logic [15:0] random_code();
    logic [7:0] lead;
    logic [7:0] trail;
    int unsigned pick;
    pick  = $urandom_range(99);
    lead  = 8'($urandom_range(ksc_pkg::LeadWideHi, ksc_pkg::LeadWideLo));
    trail = 8'($urandom_range(ksc_pkg::TrailNarHi, ksc_pkg::TrailNarLo));
    if (pick < 60) begin
      case ($urandom_range(3))
        0: begin
          case ($urandom_range(2))
            0: trail = 8'($urandom_range(ksc_pkg::TrailUpHi, ksc_pkg::TrailUpLo));
            1: trail = 8'($urandom_range(ksc_pkg::TrailLowHi, ksc_pkg::TrailLowLo));
            default: trail = 8'($urandom_range(ksc_pkg::TrailExtHi, ksc_pkg::TrailExtLo));
          endcase
        end
        1: begin
          lead = ksc_pkg::LeadTrunc;
          if ($urandom_range(1)) begin
            trail = 8'($urandom_range(ksc_pkg::TrailTruncHi, ksc_pkg::TrailUpLo));
          end
        end
        2: lead = $urandom_range(1) ? ksc_pkg::LeadC8 : ksc_pkg::LeadC7;
        default: lead = 8'($urandom_range(ksc_pkg::LeadCaHi, ksc_pkg::LeadCaLo));
      endcase
    end else if (pick < 80) begin
      case ($urandom_range(3))
        0: lead = 8'($urandom_range(ksc_pkg::LeadWideHi, ksc_pkg::LeadWideLo));
        1: lead = ksc_pkg::LeadTrunc;
        2: lead = 8'($urandom_range(ksc_pkg::LeadC8, ksc_pkg::LeadC7));
        default: lead = 8'($urandom_range(ksc_pkg::LeadCaHi, ksc_pkg::LeadCaLo));
      endcase
      trail = 8'($urandom());
    end else begin
      {lead, trail} = 16'($urandom());
    end
    return {lead, trail};
  endfunction

  task automatic send_code(logic [15:0] code);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // the upper bits of the size word are junk that the block must drop
  task automatic apply_setting(logic [23:0] base, logic [6:0] size);
    write_reg(8'($urandom_range(8'hFF, CfgSpareLo)), 24'($urandom()));
    write_reg(ksc_pkg::CfgFontBase, base);
    write_reg(ksc_pkg::CfgGlyphSize, {17'($urandom()), size});
    cfg_valid <= 1'b0;
  endtask

  // receiver side, with one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    @(negedge clk);
    forever begin
      if (rx_hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WatchdogLimit);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [15:0] corner_codes[$];
    logic [23:0] base_set[PhaseCount];
    logic [6:0]  size_set[PhaseCount];
    corner_codes = '{16'h0000, 16'hFFFF, 16'h8141, 16'h815A, 16'h8161, 16'h817A,
                     16'h8181, 16'h81FE, 16'h8140, 16'h81FF, 16'hC5FE, 16'hC641,
                     16'hC652, 16'hC653, 16'hC6A1, 16'hC6FE, 16'hC7A1, 16'hC8FE,
                     16'hC7A0, 16'hC9A1, 16'hCAA1, 16'hFDFE, 16'hFEA1, 16'h80FE,
                     16'hCAFF};
    base_set = '{ksc_pkg::FontBaseReset, BaseMax, 24'd0, 24'($urandom()), 24'($urandom()),
                 24'($urandom()), BaseMax, 24'($urandom()), 24'($urandom())};
    // zero and full-scale sizes fall outside the legal range on purpose
    size_set = '{ksc_pkg::GlyphSizeReset, 7'd64, 7'd1, 7'd0, 7'd127,
                 7'($urandom_range(MaxGlyphSize, 1)), 7'd8, 7'd9,
                 7'($urandom_range(MaxGlyphSize, 1))};
    send_gap_pct   = 15;
    recv_stall_pct = 59;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase / 3)
        0: begin send_gap_pct = 15; recv_stall_pct = 59; end
        1: begin send_gap_pct = 59; recv_stall_pct = 15; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      if (phase != 0) apply_setting(base_set[phase], size_set[phase]);
      else foreach (corner_codes[i]) send_code(corner_codes[i]);
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 1 && n == PhaseItems / 4) rx_hold_req = 1'b1;
        send_code(random_code());
      end
      in_valid <= 1'b0;
      wait (pending == 0);
      @(negedge clk);
    end

    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
